@@ src/psl_pkg.sv @@
// Shared types, constants and helpers of the per-source connection limiter.
`default_nettype none
package psl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 16;
  localparam int TOTAL_W = 22;
  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BLOCK_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOD_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOD_BLOCK_TIME = 3'd4;

  typedef enum logic [1:0] {
    FUNC_HIT    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_EXPIRE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    C_IDLE   = 3'd0,
    C_MATCH  = 3'd1,
    C_HIT    = 3'd2,
    C_REMOVE = 3'd3,
    C_EXPIRE = 3'd4,
    C_SHIFT  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] addr;
    logic [31:0] now;
    logic [15:0] burst_limit;
    logic [15:0] block_time;
    logic [15:0] window;
    logic        any_match;
  } cell_cmd_t;

  typedef struct packed {
    logic        match;
    logic        claimed;
    logic        inc;
    logic        started;
    logic [15:0] hits;
    logic [31:0] blk;
  } cell_rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] t, input logic [15:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

@@ src/psl_cell.sv @@
// One table cell: holds one source entry, matches, updates and drains its count.
`default_nettype none
module psl_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psl_pkg::cell_cmd_t  cmd,
  input  wire logic                claim_in,
  output logic                     claim_out,
  input  wire logic [15:0]         drain_in,
  output logic [15:0]              drain,
  output psl_pkg::cell_rsp_t       rsp
);

  logic        valid;
  logic [31:0] address;
  logic [31:0] created;
  logic [15:0] hits;
  logic [31:0] blk;
  logic        claim_here;
  logic [15:0] hits_inc;
  logic [15:0] hits_dec;
  logic [31:0] blk_new;
  logic        expired;

  assign claim_here = !valid && !claim_in;
  assign claim_out  = claim_in || !valid;
  assign hits_inc   = (hits != psl_pkg::HITS_MAX) ? hits + 16'd1 : hits;
  assign hits_dec   = hits - 16'd1;
  assign blk_new    = psl_pkg::sat_add(cmd.now, cmd.block_time);
  assign expired    = valid &&
                      (({1'b0, created} + {17'd0, cmd.window}) <= {1'b0, cmd.now});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      rsp.match <= 1'b0;
    end else begin
      case (cmd.op)
        psl_pkg::C_MATCH: begin
          rsp.match <= valid && (address == cmd.addr);
        end
        psl_pkg::C_HIT: begin
          if (rsp.match) begin
            hits        <= hits_inc;
            rsp.claimed <= 1'b0;
            rsp.hits    <= hits_inc;
            rsp.inc     <= (hits != psl_pkg::HITS_MAX);
            if (hits_inc > cmd.burst_limit && blk <= cmd.now) begin
              blk         <= blk_new;
              rsp.blk     <= blk_new;
              rsp.started <= 1'b1;
            end else begin
              rsp.blk     <= blk;
              rsp.started <= 1'b0;
            end
          end else if (!cmd.any_match && claim_here) begin
            valid       <= 1'b1;
            address     <= cmd.addr;
            created     <= cmd.now;
            hits        <= 16'd1;
            blk         <= 32'd0;
            rsp.claimed <= 1'b1;
            rsp.inc     <= 1'b1;
            rsp.started <= 1'b0;
            rsp.hits    <= 16'd1;
            rsp.blk     <= 32'd0;
          end else begin
            rsp.claimed <= 1'b0;
            rsp.inc     <= 1'b0;
            rsp.started <= 1'b0;
            rsp.hits    <= 16'd0;
            rsp.blk     <= 32'd0;
          end
        end
        psl_pkg::C_REMOVE: begin
          rsp.claimed <= 1'b0;
          rsp.inc     <= 1'b0;
          rsp.started <= 1'b0;
          if (rsp.match) begin
            hits <= hits_dec;
            if (hits_dec == 16'd0) begin
              valid    <= 1'b0;
              rsp.hits <= 16'd0;
              rsp.blk  <= 32'd0;
            end else begin
              rsp.hits <= hits_dec;
              rsp.blk  <= blk;
            end
          end else begin
            rsp.hits <= 16'd0;
            rsp.blk  <= 32'd0;
          end
        end
        psl_pkg::C_EXPIRE: begin
          rsp.match <= 1'b0;
          drain     <= expired ? hits : 16'd0;
          if (expired) begin
            valid <= 1'b0;
          end
        end
        psl_pkg::C_SHIFT: begin
          drain <= drain_in;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/per_source_connection_limiter.sv @@
// Top level of the per-source connection limiter: sequencer, cell row and result.
//
// Input items on s_tvalid/s_tready/s_tdata carry func, source_address and now.
// Each item yields exactly one result item on m_tvalid/m_tready/m_tdata.
// Hit, remove hit and no operation pass these steps from acceptance to result:
// match across the cell row, update of the matching or first free cell,
// total update, then flood check and result register.
// Expire instead has every cell evaluate its age at once, then the freed
// counts shift one cell per cycle toward cell 0 into a single accumulator
// that is subtracted from the running total.
// One item is processed at a time; the next item is taken in the cycle the
// current result is registered. Configuration writes (cfg_we, cfg_index,
// cfg_data) must be made while idle; the block itself does not enforce this.
// Reset empties the table, clears the total and the flood time and loads the
// default limits. A stalled receiver holds the result register; the block
// then waits in its final step and accepts nothing new until the slot frees.
`default_nettype none
module per_source_connection_limiter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // func[1:0], source_address[33:2], now[65:34], zero pad
  input  wire logic [71:0]                      s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // found[0], address_hits[16:1], address_block_until[48:17],
  // address_block_started[49], total_hits[71:50], flood_block_until[103:72],
  // flood_block_started[104], table_full[105], zero pad
  output logic [111:0]                          m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [psl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psl_pkg::CFG_W-1:0]        cfg_data
);

  localparam int N = psl_pkg::TABLE_ENTRIES;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MATCH = 6'b000010,
    ST_APPLY = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_TOTAL = 6'b010000,
    ST_FLOOD = 6'b100000
  } state_t;

  state_t                         state;
  psl_pkg::func_t                 func;
  logic [31:0]                    addr;
  logic [31:0]                    now;
  logic [15:0]                    burst_limit;
  logic [15:0]                    address_block_time;
  logic [15:0]                    burst_window;
  logic [15:0]                    flood_limit;
  logic [15:0]                    flood_block_time;
  logic [psl_pkg::IDX_W-1:0]      cnt;
  logic [psl_pkg::TOTAL_W-1:0]    acc;
  logic [psl_pkg::TOTAL_W-1:0]    total;
  logic [31:0]                    flood_until;
  logic                           res_found;
  logic                           res_claimed;
  logic [15:0]                    res_hits;
  logic [31:0]                    res_blk;
  logic                           res_started;
  logic                           res_full;
  logic                           o_found;
  logic [15:0]                    o_hits;
  logic [31:0]                    o_blk;
  logic                           o_bstart;
  logic [psl_pkg::TOTAL_W-1:0]    o_total;
  logic [31:0]                    o_flood;
  logic                           o_fstart;
  logic                           o_full;

  psl_pkg::cell_cmd_t cmd;
  psl_pkg::cell_rsp_t rsp [N];
  psl_pkg::cell_rsp_t rsp_or;
  logic               claim_chain [N+1];
  logic [15:0]        drain_row [N+1];

  logic slot_free;
  logic accept;
  logic op_acts;
  logic flood_fire;
  logic [31:0] flood_new;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) || ((state == ST_FLOOD) && slot_free);
  assign accept    = s_tvalid && s_tready;
  assign op_acts   = (func == psl_pkg::FUNC_HIT) || (func == psl_pkg::FUNC_REMOVE);
  assign flood_new = psl_pkg::sat_add(now, flood_block_time);
  assign flood_fire = (func == psl_pkg::FUNC_HIT) && (res_found || res_claimed) &&
                      (total >= psl_pkg::TOTAL_W'(flood_limit)) && (flood_until <= now);

  always_comb begin
    rsp_or = '0;
    for (int i = 0; i < N; i++) begin
      rsp_or = rsp_or | rsp[i];
    end
  end

  always_comb begin
    cmd.addr        = addr;
    cmd.now         = now;
    cmd.burst_limit = burst_limit;
    cmd.block_time  = address_block_time;
    cmd.window      = burst_window;
    cmd.any_match   = rsp_or.match;
    case (state)
      ST_MATCH: cmd.op = (func == psl_pkg::FUNC_EXPIRE) ? psl_pkg::C_EXPIRE : psl_pkg::C_MATCH;
      ST_APPLY: begin
        case (func)
          psl_pkg::FUNC_HIT:    cmd.op = psl_pkg::C_HIT;
          psl_pkg::FUNC_REMOVE: cmd.op = psl_pkg::C_REMOVE;
          default:              cmd.op = psl_pkg::C_IDLE;
        endcase
      end
      ST_DRAIN: cmd.op = psl_pkg::C_SHIFT;
      default:  cmd.op = psl_pkg::C_IDLE;
    endcase
  end

  assign claim_chain[0] = 1'b0;
  assign drain_row[N]   = 16'd0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    psl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .claim_in  (claim_chain[g]),
      .claim_out (claim_chain[g+1]),
      .drain_in  (drain_row[g+1]),
      .drain     (drain_row[g]),
      .rsp       (rsp[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit        <= 16'd5;
      address_block_time <= 16'd60;
      burst_window       <= 16'd10;
      flood_limit        <= 16'd50;
      flood_block_time   <= 16'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        psl_pkg::REG_BURST_LIMIT:      burst_limit        <= cfg_data;
        psl_pkg::REG_ADDR_BLOCK_TIME:  address_block_time <= cfg_data;
        psl_pkg::REG_BURST_WINDOW:     burst_window       <= cfg_data;
        psl_pkg::REG_FLOOD_LIMIT:      flood_limit        <= cfg_data;
        psl_pkg::REG_FLOOD_BLOCK_TIME: flood_block_time   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      total       <= '0;
      flood_until <= 32'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FLOOD)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
        end
        ST_MATCH: begin
          cnt   <= '0;
          state <= (func == psl_pkg::FUNC_EXPIRE) ? ST_DRAIN : ST_APPLY;
        end
        ST_APPLY: begin
          state <= ST_TOTAL;
        end
        ST_DRAIN: begin
          acc <= acc + psl_pkg::TOTAL_W'(drain_row[0]);
          cnt <= cnt + psl_pkg::IDX_W'(1);
          if (cnt == psl_pkg::IDX_W'(N - 1)) begin
            state <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          res_found   <= op_acts && rsp_or.match;
          res_claimed <= op_acts && rsp_or.claimed;
          res_hits    <= op_acts ? rsp_or.hits : 16'd0;
          res_blk     <= op_acts ? rsp_or.blk : 32'd0;
          res_started <= op_acts && rsp_or.started;
          res_full    <= (func == psl_pkg::FUNC_HIT) && !rsp_or.match && !rsp_or.claimed;
          case (func)
            psl_pkg::FUNC_HIT:    total <= total + psl_pkg::TOTAL_W'(rsp_or.inc);
            psl_pkg::FUNC_REMOVE: total <= total - psl_pkg::TOTAL_W'(rsp_or.match);
            psl_pkg::FUNC_EXPIRE: total <= total - acc;
            default: begin
            end
          endcase
          state <= ST_FLOOD;
        end
        ST_FLOOD: begin
          if (slot_free) begin
            o_found  <= res_found;
            o_hits   <= res_hits;
            o_blk    <= res_blk;
            o_bstart <= res_started;
            o_total  <= total;
            o_flood  <= flood_fire ? flood_new : flood_until;
            o_fstart <= flood_fire;
            o_full   <= res_full;
            m_tvalid <= 1'b1;
            if (flood_fire) begin
              flood_until <= flood_new;
            end
            if (!accept) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (accept) begin
        func  <= psl_pkg::func_t'(s_tdata[1:0]);
        addr  <= s_tdata[33:2];
        now   <= s_tdata[65:34];
        acc   <= '0;
        state <= ST_MATCH;
      end
    end
  end

  assign m_tdata = {6'd0, o_full, o_fstart, o_flood, o_total, o_bstart, o_blk, o_hits,
                    o_found};

endmodule
`default_nettype wire

@@ tb/per_source_connection_limiter_checker.sv @@
// Checker for the per-source connection limiter: predicts each result and compares it.
`timescale 1ns / 100ps
module per_source_connection_limiter_checker
  import psl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [71:0]          s_tdata,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [111:0]         m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam logic [22:0] TOTAL_CAP = 23'h7FFFFF;
  localparam logic [21:0] TOTAL_OUT_CAP = 22'h3FFFFF;

  typedef struct packed {
    logic        table_full;
    logic        flood_block_started;
    logic [31:0] flood_block_until;
    logic [21:0] total_hits;
    logic        address_block_started;
    logic [31:0] address_block_until;
    logic [15:0] address_hits;
    logic        found;
  } verdict_t;

  logic [15:0] burst_limit, addr_block_time, burst_window, flood_limit, flood_block_time;
  logic        slot_used [TABLE_ENTRIES];
  logic [31:0] slot_addr [TABLE_ENTRIES];
  logic [31:0] slot_born [TABLE_ENTRIES];
  logic [15:0] slot_hits [TABLE_ENTRIES];
  logic [31:0] slot_until [TABLE_ENTRIES];
  logic [22:0] running_total;
  logic [31:0] flood_until;
  verdict_t    expected_verdicts [$];

  function automatic logic [31:0] time_plus(input logic [31:0] t, input logic [15:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  function automatic logic [22:0] table_sum();
    logic [23:0] s;
    s = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i]) begin
        s = s + slot_hits[i];
        if (s > TOTAL_CAP) s = TOTAL_CAP;
      end
    return s[22:0];
  endfunction

  function automatic verdict_t apply_event(input func_t fn, input logic [31:0] addr,
                                           input logic [31:0] now);
    verdict_t v;
    int k;
    v = '0;
    k = -1;
    if (fn == FUNC_HIT || fn == FUNC_REMOVE)
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (k < 0 && slot_used[i] && slot_addr[i] == addr) k = i;
    case (fn)
      FUNC_HIT: begin
        if (k >= 0) begin
          v.found = 1;
          if (slot_hits[k] != HITS_MAX) begin
            slot_hits[k]++;
            if (running_total < TOTAL_CAP) running_total++;
          end
          if (slot_hits[k] > burst_limit && slot_until[k] <= now) begin
            slot_until[k] = time_plus(now, addr_block_time);
            v.address_block_started = 1;
          end
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (k < 0 && !slot_used[i]) k = i;
          if (k >= 0) begin
            slot_used[k] = 1;
            slot_addr[k] = addr;
            slot_born[k] = now;
            slot_hits[k] = 1;
            slot_until[k] = 0;
            if (running_total < TOTAL_CAP) running_total++;
          end else begin
            v.table_full = 1;
          end
        end
        if (k >= 0) begin
          v.address_hits = slot_hits[k];
          v.address_block_until = slot_until[k];
          if (running_total >= flood_limit && flood_until <= now) begin
            flood_until = time_plus(now, flood_block_time);
            v.flood_block_started = 1;
          end
        end
      end
      FUNC_REMOVE: begin
        if (k >= 0) begin
          v.found = 1;
          if (slot_hits[k] > 0) slot_hits[k]--;
          if (slot_hits[k] == 0) slot_used[k] = 0;
          else begin
            v.address_hits = slot_hits[k];
            v.address_block_until = slot_until[k];
          end
        end
        running_total = table_sum();
      end
      FUNC_EXPIRE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && ({1'b0, slot_born[i]} + burst_window) <= {1'b0, now})
            slot_used[i] = 0;
        running_total = table_sum();
      end
      default: ;
    endcase
    v.total_hits = (running_total > TOTAL_OUT_CAP) ? TOTAL_OUT_CAP : running_total[21:0];
    v.flood_block_until = flood_until;
    return v;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      burst_limit <= 5;
      addr_block_time <= 60;
      burst_window <= 10;
      flood_limit <= 50;
      flood_block_time <= 60;
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 0;
      running_total = 0;
      flood_until = 0;
      expected_verdicts.delete();
      errors <= 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_BURST_LIMIT:      burst_limit <= cfg_data;
          REG_ADDR_BLOCK_TIME:  addr_block_time <= cfg_data;
          REG_BURST_WINDOW:     burst_window <= cfg_data;
          REG_FLOOD_LIMIT:      flood_limit <= cfg_data;
          REG_FLOOD_BLOCK_TIME: flood_block_time <= cfg_data;
          default: ;
        endcase
      if (s_tvalid && s_tready)
        expected_verdicts.push_back(apply_event(func_t'(s_tdata[1:0]), s_tdata[33:2],
                                                s_tdata[65:34]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[105:0];
        if (expected_verdicts.size() == 0) report("unexpected item", got[31:0], 0);
        else begin
          want = expected_verdicts.pop_front();
          if (got.found != want.found) report("found", got.found, want.found);
          if (got.address_hits != want.address_hits)
            report("address_hits", got.address_hits, want.address_hits);
          if (got.address_block_until != want.address_block_until)
            report("address_block_until", got.address_block_until, want.address_block_until);
          if (got.address_block_started != want.address_block_started)
            report("address_block_started", got.address_block_started,
                   want.address_block_started);
          if (got.total_hits != want.total_hits)
            report("total_hits", got.total_hits, want.total_hits);
          if (got.flood_block_until != want.flood_block_until)
            report("flood_block_until", got.flood_block_until, want.flood_block_until);
          if (got.flood_block_started != want.flood_block_started)
            report("flood_block_started", got.flood_block_started, want.flood_block_started);
          if (got.table_full != want.table_full)
            report("table_full", got.table_full, want.table_full);
        end
      end
    end
  end

  assign pending = expected_verdicts.size();

endmodule

@@ tb/per_source_connection_limiter_test.sv @@
// Top of the per-source connection limiter testbench: clock, stimulus and verdict.
`timescale 1ns / 100ps
module per_source_connection_limiter_test;

  localparam int IDLE_LIMIT = 20000;

  logic                          clk = 0;
  logic                          rst = 1;
  logic                          s_tvalid = 0;
  logic                          s_tready;
  logic [71:0]                   s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 0;
  logic [111:0]                  m_tdata;
  logic                          cfg_we = 0;
  logic [psl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [psl_pkg::CFG_W-1:0]     cfg_data = '0;
  int                            errors, pending, idle_cycles;
  logic [31:0]                   clock_now = 1000;
  logic [31:0]                   addr_pool [8];

  always #4 clk = ~clk;

  per_source_connection_limiter dut (.*);
  per_source_connection_limiter_checker checker_i (.*);

  // receiver stall pattern: long runs of ready, mostly ready with jitter, and mostly stalled
  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 20000) % 3);
    if (mode == 0) m_tready <= 1;
    else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 5) == 0);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(input psl_pkg::func_t fn, input logic [31:0] addr,
                      input logic [31:0] now);
    s_tvalid <= 1;
    s_tdata <= {6'd0, now, addr, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (psl_pkg::TABLE_ENTRIES + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psl_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int n, burst, pick;
    psl_pkg::func_t fn;
    logic [31:0] addr;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) fn = psl_pkg::FUNC_HIT;
        else if (pick < 85) fn = psl_pkg::FUNC_REMOVE;
        else if (pick < 95) fn = psl_pkg::FUNC_EXPIRE;
        else fn = psl_pkg::FUNC_NOP;
        addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0) clock_now = clock_now + $urandom_range(0, 30);
        if ($urandom_range(0, 199) == 0) clock_now = $urandom;
        send(fn, addr, clock_now);
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFFFFFF;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, block, flood, saturated time, remove, expire, full table
    send(psl_pkg::FUNC_NOP, 32'h0, 32'h0);
    for (int i = 0; i < 7; i++) send(psl_pkg::FUNC_HIT, addr_pool[1], 32'd100);
    send(psl_pkg::FUNC_HIT, addr_pool[1], 32'hFFFFFFF0);
    send(psl_pkg::FUNC_REMOVE, 32'h12345678, 32'd100);
    send(psl_pkg::FUNC_REMOVE, addr_pool[1], 32'd100);
    send(psl_pkg::FUNC_HIT, addr_pool[0], 32'hFFFFFFFF);
    send(psl_pkg::FUNC_REMOVE, addr_pool[0], 32'd100);
    send(psl_pkg::FUNC_HIT, 32'hA5A5A5A5, 32'hFFFFFFFA);
    send(psl_pkg::FUNC_EXPIRE, 32'h0, 32'd5);
    send(psl_pkg::FUNC_EXPIRE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(psl_pkg::FUNC_EXPIRE, 32'h0, 32'hFFFFFFFF);
    drain();

    write_reg(psl_pkg::REG_FLOOD_LIMIT, 16'd1);
    write_reg(psl_pkg::REG_BURST_LIMIT, 16'd1);
    write_reg(psl_pkg::REG_BURST_WINDOW, 16'hFFFF);
    write_reg(psl_pkg::REG_ADDR_BLOCK_TIME, 16'hFFFF);
    write_reg(psl_pkg::REG_FLOOD_BLOCK_TIME, 16'hFFFF);
    for (int i = 0; i < psl_pkg::TABLE_ENTRIES + 2; i++)
      send(psl_pkg::FUNC_HIT, 32'hC0A80000 + i, 32'd50);
    send(psl_pkg::FUNC_EXPIRE, 32'h0, 32'hFFFFFFFF);
    drain();

    write_reg(psl_pkg::REG_BURST_LIMIT, 16'hFFFF);
    write_reg(psl_pkg::REG_FLOOD_LIMIT, 16'hFFFF);
    write_reg(psl_pkg::REG_BURST_WINDOW, 16'd0);
    write_reg(psl_pkg::REG_ADDR_BLOCK_TIME, 16'd0);
    write_reg(psl_pkg::REG_FLOOD_BLOCK_TIME, 16'd0);
    random_phase(300);

    write_reg(psl_pkg::REG_BURST_LIMIT, 16'd3);
    write_reg(psl_pkg::REG_FLOOD_LIMIT, 16'd20);
    write_reg(psl_pkg::REG_BURST_WINDOW, 16'd40);
    write_reg(psl_pkg::REG_ADDR_BLOCK_TIME, 16'd25);
    write_reg(psl_pkg::REG_FLOOD_BLOCK_TIME, 16'd15);
    write_reg(3'd7, 16'h1234);
    random_phase(500);

    write_reg(psl_pkg::REG_BURST_LIMIT, 16'd5);
    write_reg(psl_pkg::REG_FLOOD_LIMIT, 16'd50);
    write_reg(psl_pkg::REG_BURST_WINDOW, 16'd10);
    write_reg(psl_pkg::REG_ADDR_BLOCK_TIME, 16'd60);
    write_reg(psl_pkg::REG_FLOOD_BLOCK_TIME, 16'd60);
    random_phase(450);

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
src/psl_pkg.sv
src/psl_cell.sv
src/per_source_connection_limiter.sv
tb/per_source_connection_limiter_checker.sv
tb/per_source_connection_limiter_test.sv
